// ===== sv/pixel_run_length_encoder_macros.svh =====
// Assertion helpers for the pixel run-length encoder.
`ifndef PIXEL_RUN_LENGTH_ENCODER_MACROS_SVH
`define PIXEL_RUN_LENGTH_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PRLE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("prle check failed");
// next-cycle implication
`define PRLE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("prle check failed");
`else
`define PRLE_ASSERT_NOW(label, clk, rstn, ante, cons)
`define PRLE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/prle_pkg.sv =====
package prle_pkg;

    localparam int unsigned MAX_RUN   = 256;
    localparam int unsigned MAX_WIDTH = 4096;

    localparam int unsigned PIX_W  = 16;
    localparam int unsigned RUN_W  = 9;   // holds 0..MAX_RUN
    localparam int unsigned COL_W  = 12;
    localparam int unsigned ROWW_W = 13;
    localparam int unsigned CNT_W  = 8;

    localparam logic [PIX_W-1:0]  COUNT_FLAG    = 16'h0020;
    localparam logic [ROWW_W-1:0] ROW_WIDTH_RST = 13'd640;
    localparam logic [ROWW_W-1:0] ROW_WIDTH_MAX = 13'd4096;
    localparam logic [RUN_W-1:0]  RUN_LIMIT     = 9'd256;

    typedef struct packed {
        logic [PIX_W-1:0] code_word;
        logic             has_count;
        logic [CNT_W-1:0] run_count;
        logic             row_done;
        logic             last;
    } result_t;

    // Build the encoded word for one finished run.
    function automatic result_t make_run(input logic [PIX_W-1:0] pix,
                                         input logic [RUN_W-1:0] len,
                                         input logic             row_end);
        result_t          r;
        logic [RUN_W-1:0] len_m1;
        len_m1 = len - RUN_W'(1);
        if (len > RUN_W'(1)) begin
            r.code_word = pix | COUNT_FLAG;
            r.has_count = 1'b1;
            r.run_count = len_m1[CNT_W-1:0];
        end else begin
            r.code_word = pix;
            r.has_count = 1'b0;
            r.run_count = '0;
        end
        r.row_done = row_end;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/pixel_run_length_encoder.sv =====
// Pixel run-length encoder, 16-bit pixels.
// Input channel s_*: one pixel per beat, rows left to right, row after row.
// Output channel m_*: one finished run per beat. A run of one is the plain
//   pixel (m_has_count low); a longer run carries bit 5 set in m_code_word
//   and length minus one in m_run_count. m_row_done marks a row's final run,
//   m_last the final beat caused by one input pixel.
// Config: cfg_write_en / cfg_write_data set the row width (0 acts as 1,
//   above 4096 acts as 4096). Write only while idle.
// Latency: a run closed by a pixel shows on m_* the cycle after that pixel
//   is accepted. Pixels that only extend a run produce no beat.
// Throughput: one pixel per clock while each pixel yields at most one beat
//   and m_ready is high. A pixel that both flushes a run and closes a row
//   yields two beats; the next pixel waits for the first to be popped.
// Reset (aresetn low, synchronous): row width back to 640, no run held,
//   column zero, result queue empty.
// Receiver stall: beats wait in the queue; s_ready drops once the queue can
//   no longer take a worst-case pair.
module pixel_run_length_encoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_write_en,
    input  logic [prle_pkg::ROWW_W-1:0]     cfg_write_data,
    // pixel input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [prle_pkg::PIX_W-1:0]      s_pixel,
    // run output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [prle_pkg::PIX_W-1:0]      m_code_word,
    output logic                            m_has_count,
    output logic [prle_pkg::CNT_W-1:0]      m_run_count,
    output logic                            m_row_done,
    output logic                            m_last
);
    import prle_pkg::*;

`include "pixel_run_length_encoder_macros.svh"

    // run state
    logic [ROWW_W-1:0] width_reg;      // already clamped to 1..MAX_WIDTH
    logic [PIX_W-1:0]  held_reg,   held_next;
    logic [RUN_W-1:0]  run_reg,    run_next;
    logic [COL_W-1:0]  col_reg,    col_next;

    // two-entry result queue, q0 is the head
    result_t           q0_reg, q0_next;
    result_t           q1_reg, q1_next;
    logic [1:0]        cnt_reg, cnt_next;

    logic              push, pop;
    logic              flush, row_end, run_full, second;
    logic [RUN_W-1:0]  run_a, run_b;
    logic [PIX_W-1:0]  held_a;
    logic [ROWW_W-1:0] col_inc;
    result_t           run_old, run_new, r0, r1;
    logic [1:0]        n_res;

    assign m_valid     = (cnt_reg != 2'd0);
    assign m_code_word = q0_reg.code_word;
    assign m_has_count = q0_reg.has_count;
    assign m_run_count = q0_reg.run_count;
    assign m_row_done  = q0_reg.row_done;
    assign m_last      = q0_reg.last;

    assign pop     = m_valid && m_ready;
    // take a pixel only when the queue is empty after this cycle's pop,
    // so a two-beat pixel always fits
    assign s_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign push    = s_valid && s_ready;

    // per-pixel run logic
    always_comb begin
        flush    = (run_reg != '0) && (s_pixel != held_reg);
        run_a    = flush ? '0 : run_reg;
        held_a   = (run_a == '0) ? s_pixel : held_reg;
        run_b    = run_a + RUN_W'(1);
        col_inc  = {1'b0, col_reg} + ROWW_W'(1);
        row_end  = (col_inc >= width_reg);
        run_full = (run_b >= RUN_LIMIT);
        second   = row_end || run_full;

        run_old  = make_run(held_reg, run_reg, 1'b0);
        run_new  = make_run(held_a, run_b, row_end);

        r0 = flush ? run_old : run_new;
        r1 = run_new;
        if (flush && second) begin
            r1.last = 1'b1;
        end else begin
            r0.last = 1'b1;
        end
        n_res = {1'b0, flush} + {1'b0, second};

        held_next = held_a;
        run_next  = second ? '0 : run_b;
        col_next  = row_end ? '0 : col_inc[COL_W-1:0];
    end

    // queue update
    always_comb begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (push) begin
            q0_next  = r0;
            q1_next  = r1;
            cnt_next = n_res;
        end else if (pop) begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= ROW_WIDTH_RST;
            held_reg  <= '0;
            run_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            if (cfg_write_en) begin
                if (cfg_write_data == '0) begin
                    width_reg <= ROWW_W'(1);
                end else if (cfg_write_data > ROW_WIDTH_MAX) begin
                    width_reg <= ROW_WIDTH_MAX;
                end else begin
                    width_reg <= cfg_write_data;
                end
            end
            if (push) begin
                held_reg <= held_next;
                run_reg  <= run_next;
                col_reg  <= col_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    `PRLE_ASSERT_NOW(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg != 2'd3)
    `PRLE_ASSERT_NOW(a_pair_order, aclk, aresetn, cnt_reg == 2'd2,
        !q0_reg.last && q1_reg.last)
    `PRLE_ASSERT_NOW(a_run_bound, aclk, aresetn, 1'b1, run_reg < RUN_LIMIT)
    `PRLE_ASSERT_NEXT(a_row_wrap, aclk, aresetn, push && row_end,
        col_reg == '0 && run_reg == '0)
    `PRLE_ASSERT_NEXT(a_drain, aclk, aresetn, pop && !push && cnt_reg == 2'd1,
        !m_valid)

endmodule
